// ===== rtl/rectangle_raster_fill_assert.svh =====
// ----------------------------------------------------------------------------
// rectangle_raster_fill_assert.svh
// Assertion macros shared by the rectangle rasterizer checks.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_RASTER_FILL_ASSERT_SVH
`define RECTANGLE_RASTER_FILL_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define RRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rectangle_raster_fill: same-cycle check failed");

// Next-cycle implication.
`define RRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rectangle_raster_fill: next-cycle check failed");

`endif

// ===== rtl/rrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rrf_pkg
// Types, codes and sizes shared by the rectangle rasterizer modules.
// ----------------------------------------------------------------------------
package rrf_pkg;

    // Canvas geometry
    localparam int MAX_SIDE  = 256;
    localparam int IDX_W     = $clog2(MAX_SIDE);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int SIDE_W    = 9;

    // Fixed-point coordinates
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 24;
    localparam int BND_W     = COORD_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd2;

    localparam logic [SIDE_W-1:0] RST_WIDTH      = 9'd256;
    localparam logic [SIDE_W-1:0] RST_HEIGHT     = 9'd256;
    localparam logic [7:0]        RST_BACKGROUND = 8'd32;

    // Command codes
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] CODE_FILLED  = 8'h52;  // 'R'
    localparam logic [7:0] CODE_OUTLINE = 8'h72;  // 'r'

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    // Input word
    typedef struct packed {
        logic [1:0]                func;
        logic [7:0]                shape_code;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic signed [COORD_W-1:0] rect_width;
        logic signed [COORD_W-1:0] rect_height;
        logic [7:0]                paint_color;
        logic [7:0]                read_col;
        logic [7:0]                read_row;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic [7:0] pixel_value;
        logic [1:0] status;
    } res_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic walk_step;
        logic res_load;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic do_walk;
        logic walk_last;
        logic res_free;
    } stat_t;

    // Size register clamped to the canvas store
    function automatic logic [SIDE_W-1:0] used_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] lim;
        lim = SIDE_W'(MAX_SIDE);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== rtl/rrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrf_ctrl
// Sequencer: accept, decode, pixel walk, result hand-off.
// ----------------------------------------------------------------------------
module rrf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  rrf_pkg::stat_t stat,
    output rrf_pkg::ctrl_t ctl
);

    rrf_pkg::state_t state_reg;
    rrf_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrf_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = rrf_pkg::S_DECODE;
                end
            end
            rrf_pkg::S_DECODE:
            begin
                state_next = stat.do_walk ? rrf_pkg::S_WALK : rrf_pkg::S_FINISH;
            end
            rrf_pkg::S_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = rrf_pkg::S_FINISH;
                end
            end
            rrf_pkg::S_FINISH:
            begin
                if (stat.res_free)
                begin
                    state_next = rrf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rrf_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_ready     = 1'b0;
        ctl           = '0;
        unique case (state_reg)
            rrf_pkg::S_IDLE:
            begin
                cmd_ready  = 1'b1;
                ctl.accept = cmd_valid;
            end
            rrf_pkg::S_DECODE:
            begin
                ctl.decode = 1'b1;
            end
            rrf_pkg::S_WALK:
            begin
                ctl.walk_step = 1'b1;
            end
            rrf_pkg::S_FINISH:
            begin
                ctl.res_load = stat.res_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/rrf_datapath.sv =====
// ----------------------------------------------------------------------------
// rrf_datapath
// Command and bound registers, pixel walk counters, coverage test,
// canvas store and result register.
// ----------------------------------------------------------------------------
module rrf_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rrf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rrf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  rrf_pkg::cmd_t                     cmd,
    input  rrf_pkg::ctrl_t                    ctl,
    output rrf_pkg::stat_t                    stat,
    output logic                              res_valid,
    input  logic                              res_ready,
    output rrf_pkg::res_t                     res
);

    localparam int IDX_W  = rrf_pkg::IDX_W;
    localparam int BND_W  = rrf_pkg::BND_W;
    localparam int SIDE_W = rrf_pkg::SIDE_W;
    localparam logic signed [BND_W-1:0] ONE_S = BND_W'(1) << rrf_pkg::FRAC_BITS;

    // Configuration registers
    logic [SIDE_W-1:0] width_cfg_reg;
    logic [SIDE_W-1:0] height_cfg_reg;
    logic [7:0]        bg_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= rrf_pkg::RST_WIDTH;
            height_cfg_reg <= rrf_pkg::RST_HEIGHT;
            bg_cfg_reg     <= rrf_pkg::RST_BACKGROUND;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rrf_pkg::CFG_WIDTH:      width_cfg_reg  <= cfg_data;
                rrf_pkg::CFG_HEIGHT:     height_cfg_reg <= cfg_data;
                rrf_pkg::CFG_BACKGROUND: bg_cfg_reg     <= cfg_data[7:0];
                default:                 bg_cfg_reg     <= bg_cfg_reg;
            endcase
        end
    end

    logic [SIDE_W-1:0] used_w;
    logic [SIDE_W-1:0] used_h;
    assign used_w = rrf_pkg::used_side(width_cfg_reg);
    assign used_h = rrf_pkg::used_side(height_cfg_reg);

    // Captured input word
    rrf_pkg::cmd_t cmd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // Decode of the held word
    logic is_draw;
    logic is_read;
    logic is_clear;
    logic bad_rect;
    logic draw_go;
    logic read_out;
    logic filled;
    logic [1:0] status_dec;
    logic err_latch_reg;

    assign is_draw  = (cmd_reg.func == rrf_pkg::FUNC_DRAW);
    assign is_read  = (cmd_reg.func == rrf_pkg::FUNC_READ);
    assign is_clear = (cmd_reg.func == rrf_pkg::FUNC_CLEAR);
    assign bad_rect = cmd_reg.rect_width[rrf_pkg::COORD_W-1]
                   || (cmd_reg.rect_width == '0)
                   || cmd_reg.rect_height[rrf_pkg::COORD_W-1]
                   || (cmd_reg.rect_height == '0)
                   || ((cmd_reg.shape_code != rrf_pkg::CODE_FILLED)
                       && (cmd_reg.shape_code != rrf_pkg::CODE_OUTLINE));
    assign draw_go  = is_draw && !err_latch_reg && !bad_rect;
    assign read_out = ({1'b0, cmd_reg.read_col} >= used_w)
                   || ({1'b0, cmd_reg.read_row} >= used_h);
    assign filled   = (cmd_reg.shape_code == rrf_pkg::CODE_FILLED);

    always_comb
    begin
        status_dec = rrf_pkg::ST_OK;
        if (is_draw && err_latch_reg)
        begin
            status_dec = rrf_pkg::ST_IGNORED;
        end
        else if (is_draw && bad_rect)
        begin
            status_dec = rrf_pkg::ST_INVALID;
        end
        else if (is_read && read_out)
        begin
            status_dec = rrf_pkg::ST_OUTSIDE;
        end
    end

    // Sticky error and decoded status
    logic [1:0] status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_latch_reg <= 1'b0;
        end
        else if (ctl.decode)
        begin
            if (is_clear)
            begin
                err_latch_reg <= 1'b0;
            end
            else if (is_draw && bad_rect)
            begin
                err_latch_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.decode)
        begin
            status_reg <= status_dec;
        end
    end

    // Rectangle bounds: outer and one-pixel-inset limits per axis
    logic signed [BND_W-1:0] x_lo;
    logic signed [BND_W-1:0] y_lo;
    logic signed [BND_W-1:0] x_hi_reg;
    logic signed [BND_W-1:0] y_hi_reg;
    logic signed [BND_W-1:0] x_in_lo_reg;
    logic signed [BND_W-1:0] y_in_lo_reg;
    logic signed [BND_W-1:0] x_in_hi_reg;
    logic signed [BND_W-1:0] y_in_hi_reg;
    logic signed [BND_W-1:0] x_hi;
    logic signed [BND_W-1:0] y_hi;

    assign x_lo = BND_W'(cmd_reg.rect_x);
    assign y_lo = BND_W'(cmd_reg.rect_y);
    assign x_hi = x_lo + BND_W'(cmd_reg.rect_width);
    assign y_hi = y_lo + BND_W'(cmd_reg.rect_height);

    always_ff @(posedge clk)
    begin
        if (ctl.decode)
        begin
            x_hi_reg    <= x_hi;
            y_hi_reg    <= y_hi;
            x_in_lo_reg <= x_lo + ONE_S;
            y_in_lo_reg <= y_lo + ONE_S;
            x_in_hi_reg <= x_hi - ONE_S;
            y_in_hi_reg <= y_hi - ONE_S;
        end
    end

    // Walk counters, back at zero after every walk
    logic [IDX_W-1:0] walk_col_reg;
    logic [IDX_W-1:0] walk_row_reg;
    logic [IDX_W-1:0] walk_col_next;
    logic [IDX_W-1:0] walk_row_next;
    logic col_last;
    logic row_last;

    assign col_last = ({1'b0, walk_col_reg} == (used_w - SIDE_W'(1)));
    assign row_last = ({1'b0, walk_row_reg} == (used_h - SIDE_W'(1)));

    always_comb
    begin
        walk_col_next = walk_col_reg;
        walk_row_next = walk_row_reg;
        if (ctl.walk_step)
        begin
            if (col_last)
            begin
                walk_col_next = '0;
                walk_row_next = row_last ? '0 : walk_row_reg + IDX_W'(1);
            end
            else
            begin
                walk_col_next = walk_col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_col_reg <= '0;
            walk_row_reg <= '0;
        end
        else
        begin
            walk_col_reg <= walk_col_next;
            walk_row_reg <= walk_row_next;
        end
    end

    // Coverage test of the current pixel
    logic signed [BND_W-1:0] pc;
    logic signed [BND_W-1:0] pr;
    logic covered;
    logic on_edge;
    logic wr_en;
    logic [7:0] wr_data;

    assign pc      = BND_W'(walk_col_reg) << rrf_pkg::FRAC_BITS;
    assign pr      = BND_W'(walk_row_reg) << rrf_pkg::FRAC_BITS;
    assign covered = (pc >= x_lo) && (pc <= x_hi_reg) && (pr >= y_lo) && (pr <= y_hi_reg);
    assign on_edge = (pc < x_in_lo_reg) || (pc > x_in_hi_reg)
                  || (pr < y_in_lo_reg) || (pr > y_in_hi_reg);
    assign wr_en   = ctl.walk_step && (is_clear || (covered && (on_edge || filled)));
    assign wr_data = is_clear ? bg_cfg_reg : cmd_reg.paint_color;

    // Canvas store: one write and one registered read per cycle
    logic [7:0] canvas_mem [rrf_pkg::DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            canvas_mem[{walk_row_reg, walk_col_reg}] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= canvas_mem[{IDX_W'(cmd_reg.read_row), IDX_W'(cmd_reg.read_col)}];
    end

    // Result register
    logic res_valid_reg;
    logic res_valid_next;
    rrf_pkg::res_t res_reg;
    rrf_pkg::res_t res_next;

    always_comb
    begin
        res_next.status      = status_reg;
        res_next.pixel_value = (is_read && (status_reg == rrf_pkg::ST_OK)) ? rd_data_reg : 8'd0;
        res_valid_next       = res_valid_reg;
        if (ctl.res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Status to the controller
    assign stat.do_walk   = (is_clear || draw_go) && (used_w != '0) && (used_h != '0);
    assign stat.walk_last = col_last && row_last;
    assign stat.res_free  = !res_valid_reg || res_ready;

endmodule

// ===== rtl/rectangle_raster_fill.sv =====
// ----------------------------------------------------------------------------
// rectangle_raster_fill
// Byte canvas with rectangle fill/outline drawing, clear and pixel read.
// ----------------------------------------------------------------------------
// Sequence: a read, an ignored or invalid draw, or an unknown command goes
// from acceptance through decode to finish, where its result word enters the
// output register as the sequencer returns to idle and frees the input; a
// clear or a valid draw first walks all W*H pixels in use once each, where W
// and H are the canvas size registers (clamped to 256), one pixel per cycle
// through the single write port of the canvas memory. A new word is accepted
// only after the previous one has handed its result to the output register,
// which can still wait for the consumer. The canvas holds no reset value:
// issue a clear before reading any pixel.
`include "rectangle_raster_fill_assert.svh"

module rectangle_raster_fill (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rrf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  rrf_pkg::cmd_t                  cmd,
    output logic                           res_valid,
    input  logic                           res_ready,
    output rrf_pkg::res_t                  res
);

    rrf_pkg::ctrl_t ctl;
    rrf_pkg::stat_t stat;

    // Sequencer
    rrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Datapath and canvas
    rrf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Checks
    `RRF_ASSERT_NEXT(a_one_word_at_a_time, cmd_valid && cmd_ready, !cmd_ready)
    `RRF_ASSERT_NOW(a_load_into_free_slot, ctl.res_load, !res_valid || res_ready)
    `RRF_ASSERT_NOW(a_no_walk_while_idle, cmd_ready, !ctl.walk_step && !ctl.res_load)

endmodule
